### hdl/ple_pkg.sv
package ple_pkg;

   // Element width and the width of index fields carried to the cells.
   // Index fields are sized for the largest supported list (4096 entries).
   localparam int DATA_W = 32;
   localparam int POS_W  = 13;

   // Request operations (req_tuser)
   localparam logic [2:0] MODE_CLEAR   = 3'd0;
   localparam logic [2:0] MODE_INSERT  = 3'd1;
   localparam logic [2:0] MODE_DELETE  = 3'd2;
   localparam logic [2:0] MODE_LOCATE  = 3'd3;
   localparam logic [2:0] MODE_REVERSE = 3'd4;
   localparam logic [2:0] MODE_DEDUP   = 3'd5;

   // Per-cycle action of every cell in the row
   localparam logic [1:0] CELL_HOLD = 2'd0;  // keep contents
   localparam logic [1:0] CELL_INS  = 2'd1;  // open a slot at idx, shift up
   localparam logic [1:0] CELL_DEL  = 2'd2;  // close the slot at idx, shift down
   localparam logic [1:0] CELL_ROT  = 2'd3;  // shift down below idx, head lands at idx

   // Broadcast from the sequencer to the whole row
   typedef struct packed {
      logic [1:0]        op;
      logic              find;   // token chain carries match positions
      logic              wr;     // ROT: write head into cell idx
      logic [POS_W-1:0]  idx;
      logic [POS_W-1:0]  count;
      logic [DATA_W-1:0] val;
      logic [DATA_W-1:0] head;   // contents of cell 0
   } cell_ctrl_type;

endpackage

### hdl/ple_cell.sv
module ple_cell #(
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  ple_pkg::cell_ctrl_type       ctrl,
   input  logic [ple_pkg::DATA_W-1:0]   left_data,
   input  logic [ple_pkg::DATA_W-1:0]   right_data,
   input  logic [ple_pkg::DATA_W-1:0]   right_tok,
   output logic [ple_pkg::DATA_W-1:0]   data,
   output logic [ple_pkg::DATA_W-1:0]   tok
);

   localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(INDEX);

   logic [ple_pkg::DATA_W-1:0] data_ff, data_in;
   logic [ple_pkg::DATA_W-1:0] tok_ff, tok_in;
   logic                       in_list;
   logic                       src;
   logic [ple_pkg::DATA_W-1:0] own;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         ple_pkg::CELL_HOLD: data_in = data_ff;
         ple_pkg::CELL_INS: begin
            if (MY_IDX > ctrl.idx) begin
               data_in = left_data;
            end else if (MY_IDX == ctrl.idx) begin
               data_in = ctrl.val;
            end
         end
         ple_pkg::CELL_DEL: begin
            if (MY_IDX >= ctrl.idx) begin
               data_in = right_data;
            end
         end
         ple_pkg::CELL_ROT: begin
            if (MY_IDX < ctrl.idx) begin
               data_in = right_data;
            end else if (MY_IDX == ctrl.idx && ctrl.wr) begin
               data_in = ctrl.head;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // Token chain runs toward cell 0; the lowest source wins.
   // Locate: an empty cell sources 0, a matching cell its 1-based position.
   always_comb begin
      in_list = MY_IDX < ctrl.count;
      if (ctrl.find) begin
         src = !in_list || (data_ff == ctrl.val);
         own = in_list ? ple_pkg::DATA_W'(INDEX + 1) : '0;
      end else begin
         src = MY_IDX == ctrl.idx;
         own = data_ff;
      end
      tok_in = src ? own : right_tok;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tok_ff  <= tok_in;
   end

   assign data = data_ff;
   assign tok  = tok_ff;

endmodule

### hdl/ple_ctrl.sv
module ple_ctrl #(
   parameter int CAPACITY = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_mode,
   input  logic [7:0]                   req_position,
   input  logic [ple_pkg::DATA_W-1:0]   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_ok,
   output logic [ple_pkg::DATA_W-1:0]   rsp_removed_value,
   output logic [7:0]                   rsp_found_position,
   output logic [7:0]                   rsp_list_length,
   input  logic [ple_pkg::DATA_W-1:0]   head,
   input  logic [ple_pkg::DATA_W-1:0]   tok0,
   output ple_pkg::cell_ctrl_type       ctrl
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                       state_ff, state_in;
   logic [2:0]                 mode_ff, mode_in;
   logic [7:0]                 pos_ff, pos_in;
   logic [ple_pkg::DATA_W-1:0] val_ff, val_in;
   logic                       pass_ff, pass_in;
   logic [CW-1:0]              r_ff, r_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [ple_pkg::DATA_W-1:0] last_ff, last_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       rvalid_ff, rvalid_in;
   logic                       rok_ff, rok_in;
   logic [ple_pkg::DATA_W-1:0] rrem_ff, rrem_in;
   logic [7:0]                 rfound_ff, rfound_in;
   logic [7:0]                 rlen_ff, rlen_in;

   logic            accept;
   logic [CMPW-1:0] pos_ext, cnt_ext;
   logic            ins_ok, del_ok;
   logic            keep;
   logic            out_free;
   logic [ple_pkg::POS_W-1:0] slot_idx;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rvalid_ff || rsp_ready;

   assign pos_ext = CMPW'(req_position);
   assign cnt_ext = CMPW'(count_ff);
   assign ins_ok  = (req_position != 8'd0) && (pos_ext <= cnt_ext + CMPW'(1))
                    && (count_ff < CW'(CAPACITY));
   assign del_ok  = (req_position != 8'd0) && (pos_ext <= cnt_ext);

   assign keep     = (k_ff == '0) || (head != last_ff);
   assign slot_idx = ple_pkg::POS_W'(pos_ff) - ple_pkg::POS_W'(1);

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      pass_in   = pass_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      rok_in    = rok_ff;
      rrem_in   = rrem_ff;
      rfound_in = rfound_ff;
      rlen_in   = rlen_ff;

      ctrl       = '0;
      ctrl.op    = ple_pkg::CELL_HOLD;
      ctrl.idx   = slot_idx;
      ctrl.count = ple_pkg::POS_W'(count_ff);
      ctrl.val   = val_ff;
      ctrl.head  = head;
      ctrl.find  = mode_ff == ple_pkg::MODE_LOCATE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               mode_in  = req_mode;
               pos_in   = req_position;
               val_in   = req_value;
               k_in     = '0;
               pass_in  = 1'b0;
               r_in     = '0;
               unique case (req_mode)
                  ple_pkg::MODE_INSERT: pass_in = ins_ok;
                  ple_pkg::MODE_DELETE: begin
                     pass_in = del_ok;
                     r_in    = del_ok ? CW'(CAPACITY) : '0;
                  end
                  ple_pkg::MODE_LOCATE: r_in = CW'(CAPACITY);
                  ple_pkg::MODE_REVERSE: begin
                     r_in = (count_ff < CW'(2)) ? '0 : count_ff - CW'(1);
                  end
                  ple_pkg::MODE_DEDUP: begin
                     pass_in = count_ff >= CW'(2);
                     r_in    = (count_ff < CW'(2)) ? '0 : count_ff;
                  end
                  default: pass_in = 1'b0;
               endcase
            end
         end
         ST_RUN: begin
            if (r_ff != '0) begin
               r_in = r_ff - CW'(1);
               if (mode_ff == ple_pkg::MODE_REVERSE) begin
                  ctrl.op  = ple_pkg::CELL_ROT;
                  ctrl.idx = ple_pkg::POS_W'(r_ff);
                  ctrl.wr  = 1'b1;
               end else if (mode_ff == ple_pkg::MODE_DEDUP) begin
                  ctrl.op  = ple_pkg::CELL_ROT;
                  ctrl.idx = ple_pkg::POS_W'(CW'(r_ff + k_ff - CW'(1)));
                  ctrl.wr  = keep;
                  if (keep) begin
                     k_in    = k_ff + CW'(1);
                     last_in = head;
                  end
               end
            end else if (out_free) begin
               state_in  = ST_IDLE;
               rvalid_in = 1'b1;
               rok_in    = 1'b0;
               rrem_in   = '0;
               rfound_in = '0;
               unique case (mode_ff)
                  ple_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     rok_in   = 1'b1;
                  end
                  ple_pkg::MODE_INSERT: begin
                     rok_in = pass_ff;
                     if (pass_ff) begin
                        ctrl.op  = ple_pkg::CELL_INS;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ple_pkg::MODE_DELETE: begin
                     rok_in = pass_ff;
                     if (pass_ff) begin
                        ctrl.op  = ple_pkg::CELL_DEL;
                        count_in = count_ff - CW'(1);
                        rrem_in  = tok0;
                     end
                  end
                  ple_pkg::MODE_LOCATE: begin
                     rok_in    = 1'b1;
                     rfound_in = tok0[7:0];
                  end
                  ple_pkg::MODE_REVERSE: rok_in = 1'b1;
                  ple_pkg::MODE_DEDUP: begin
                     rok_in = 1'b1;
                     if (pass_ff) begin
                        count_in = k_ff;
                     end
                  end
                  default: rok_in = 1'b0;
               endcase
               rlen_in = 8'(count_in);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      pass_ff   <= pass_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      last_ff   <= last_in;
      rok_ff    <= rok_in;
      rrem_ff   <= rrem_in;
      rfound_ff <= rfound_in;
      rlen_ff   <= rlen_in;
   end

   assign rsp_valid          = rvalid_ff;
   assign rsp_ok             = rok_ff;
   assign rsp_removed_value  = rrem_ff;
   assign rsp_found_position = rfound_ff;
   assign rsp_list_length    = rlen_ff;

endmodule

### hdl/positional_list_engine.sv
// Ordered list of signed 32-bit values, up to CAPACITY entries, kept in a row
// of cells (one entry per cell) that shift to their neighbors. Each request
// transaction carries an operation in req_tuser: clear, insert at a 1-based
// position, delete at a 1-based position, locate first match, reverse, dedup.
// Every request gives one response transaction. One request is worked at a
// time; the next is taken once the previous result is in the output register,
// so a new request can enter while that result still waits. Clear and insert
// answer without stepping; delete (in range) and locate first step the token
// chain, which walks a stored value or a match position down the row to cell
// 0; reverse and dedup of a list of n >= 2 entries move one head element per
// cycle. A rejected insert or delete and a reverse or dedup of a short list
// answer without stepping either. req_tready is high again in the same cycle
// as rsp_tvalid; a request's end waits while the response register is full.
// Unused operation codes answer ok = 0 and change nothing. The store needs no
// clearing after reset: only entries below the length are ever read.
module positional_list_engine #(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] position, [39:8] value
   input  logic [2:0]  req_tuser,   // [2:0] mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [0] ok, [32:1] removed_value,
                                    // [40:33] found_position,
                                    // [48:41] list_length, [55:49] zero
);

   logic [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];
   logic [ple_pkg::DATA_W-1:0] cell_tok  [CAPACITY];
   ple_pkg::cell_ctrl_type     ctrl;

   logic                       rsp_ok;
   logic [ple_pkg::DATA_W-1:0] rsp_removed_value;
   logic [7:0]                 rsp_found_position;
   logic [7:0]                 rsp_list_length;

   // Sequencer: handshake, list length, per-operation step counting and the
   // response register.
   ple_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_mode           (req_tuser),
      .req_position       (req_tdata[7:0]),
      .req_value          (req_tdata[39:8]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_ok             (rsp_ok),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length),
      .head               (cell_data[0]),
      .tok0               (cell_tok[0]),
      .ctrl               (ctrl)
   );

   // Row of cells: data moves up on insert, down on delete and rotate;
   // tokens always move toward cell 0. Ends of the row see zeros.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ple_pkg::DATA_W-1:0] left_d;
      logic [ple_pkg::DATA_W-1:0] right_d;
      logic [ple_pkg::DATA_W-1:0] right_t;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
         assign right_t = '0;
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
         assign right_t = cell_tok[i+1];
      end

      ple_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .right_tok  (right_t),
         .data       (cell_data[i]),
         .tok        (cell_tok[i])
      );
   end

   assign rsp_tdata = {7'd0, rsp_list_length, rsp_found_position,
                       rsp_removed_value, rsp_ok};

endmodule
